/* design/mrw_pkg.sv */
// Package for the Miller-Rabin witness test core.
// Holds the operand width, the counter width and sequencer codes; no dependencies.
package mrw_pkg;
   localparam int WIDTH = 64;
   localparam int CNT_W = $clog2(WIDTH);

   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] S_IDLE   = 3'd0;
   localparam logic [ST_W-1:0] S_DECOMP = 3'd1;
   localparam logic [ST_W-1:0] S_MWAIT  = 3'd2;
   localparam logic [ST_W-1:0] S_POW    = 3'd3;
   localparam logic [ST_W-1:0] S_TEST   = 3'd4;
   localparam logic [ST_W-1:0] S_SQ     = 3'd5;
   localparam logic [ST_W-1:0] S_SQCHK  = 3'd6;
   localparam logic [ST_W-1:0] S_DONE   = 3'd7;

   localparam logic DST_ACC  = 1'b0;
   localparam logic DST_BASE = 1'b1;

   typedef logic [WIDTH-1:0] word_type;
endpackage

/* design/mrw_if.sv */
// Handshake channels for the Miller-Rabin witness test core.
// The operand fields are written as 64 bits wide and do not use mrw_pkg.
interface mrw_req_if;
   logic                     valid;
   logic                     ready;
   logic [63:0]              candidate;
   logic [63:0]              witness;
   modport source (output valid, candidate, witness, input ready);
   modport sink   (input valid, candidate, witness, output ready);
endinterface

interface mrw_rsp_if;
   logic valid;
   logic ready;
   logic composite;
   modport source (output valid, composite, input ready);
   modport sink   (input valid, composite, output ready);
endinterface

/* design/mrw_mulmod.sv */
// Bit-serial modular multiplier: result = x * y mod n, one bit of y per cycle.
// Requires x < n; depends on mrw_pkg.
module mrw_mulmod (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  mrw_pkg::word_type   x,
   input  mrw_pkg::word_type   y,
   input  mrw_pkg::word_type   n,
   output logic                done,
   output mrw_pkg::word_type   result
);
   import mrw_pkg::*;

   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   word_type             acc_ff, acc_in, x_ff, x_in, y_ff, y_in, n_ff, n_in;
   logic [WIDTH+1:0]     sum, n1, n2;

   // 2*acc + x*bit stays below 3n, so one of two parallel compares settles it.
   always_comb begin
      sum = {1'b0, acc_ff, 1'b0} + (y_ff[WIDTH-1] ? {2'b00, x_ff} : '0);
      n1  = {2'b00, n_ff};
      n2  = {1'b0, n_ff, 1'b0};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      n_in    = n_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(WIDTH - 1);
         acc_in  = '0;
         x_in    = x;
         y_in    = y;
         n_in    = n;
      end else if (busy_ff) begin
         priority if (sum >= n2) acc_in = WIDTH'(sum - n2);
         else if (sum >= n1)     acc_in = WIDTH'(sum - n1);
         else                    acc_in = WIDTH'(sum);
         y_in = {y_ff[WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      n_ff   <= n_in;
   end

   assign done   = done_ff;
   assign result = acc_ff;
endmodule

/* design/miller_rabin_witness_test_core.sv */
// One Miller-Rabin round per request beat: the response beat says whether the witness
// proves the candidate composite. All arithmetic runs on the single bit-serial modular
// multiplier, which does the witness reduction, every square and every multiply.
// Candidates below 4 skip it and go straight to the response. The request side is not
// ready until the response beat has been taken.
module miller_rabin_witness_test_core (
   input logic     clock,
   input logic     reset,
   mrw_req_if.sink   req_bus,
   mrw_rsp_if.source rsp_bus
);
   import mrw_pkg::*;

   logic [ST_W-1:0]  state_ff, state_in, ret_ff, ret_in;
   logic             dst_ff, dst_in, mult_done_ff, mult_done_in;
   logic             comp_ff, comp_in, start_ff, start_in;
   word_type         n_ff, n_in, nm1_ff, nm1_in, exp_ff, exp_in;
   word_type         acc_ff, acc_in, base_ff, base_in, wit_ff, wit_in;
   word_type         mx_ff, mx_in, my_ff, my_in, mm_result;
   logic [CNT_W-1:0] s_ff, s_in, left_ff, left_in;
   logic             mm_done;
   word_type         cand;

   mrw_mulmod u_mulmod (
      .clock (clock),
      .reset (reset),
      .start (start_ff),
      .x     (mx_ff),
      .y     (my_ff),
      .n     (n_ff),
      .done  (mm_done),
      .result(mm_result)
   );

   assign cand = req_bus.candidate[WIDTH-1:0];

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      dst_in       = dst_ff;
      mult_done_in = mult_done_ff;
      comp_in      = comp_ff;
      start_in     = 1'b0;
      n_in         = n_ff;
      nm1_in       = nm1_ff;
      exp_in       = exp_ff;
      acc_in       = acc_ff;
      base_in      = base_ff;
      wit_in       = wit_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      s_in         = s_ff;
      left_in      = left_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               n_in   = cand;
               nm1_in = cand - 1'b1;
               exp_in = cand - 1'b1;
               wit_in = req_bus.witness[WIDTH-1:0];
               s_in   = '0;
               if (cand < WIDTH'(4)) begin
                  comp_in  = !(cand == WIDTH'(2) || cand == WIDTH'(3));
                  state_in = S_DONE;
               end else begin
                  state_in = S_DECOMP;
               end
            end
         end
         S_DECOMP: begin
            if (exp_ff[0]) begin
               // Reduce the witness: 1 * witness mod n through the multiplier.
               acc_in       = WIDTH'(1);
               mx_in        = WIDTH'(1);
               my_in        = wit_ff;
               dst_in       = DST_BASE;
               ret_in       = S_POW;
               mult_done_in = 1'b0;
               start_in     = 1'b1;
               state_in     = S_MWAIT;
            end else begin
               exp_in = exp_ff >> 1;
               s_in   = s_ff + 1'b1;
            end
         end
         S_MWAIT: begin
            if (mm_done) begin
               if (dst_ff == DST_BASE) base_in = mm_result;
               else                    acc_in  = mm_result;
               state_in = ret_ff;
            end
         end
         S_POW: begin
            priority if (exp_ff == '0) begin
               state_in = S_TEST;
            end else if (exp_ff[0] && !mult_done_ff) begin
               mx_in        = acc_ff;
               my_in        = base_ff;
               dst_in       = DST_ACC;
               ret_in       = S_POW;
               mult_done_in = 1'b1;
               start_in     = 1'b1;
               state_in     = S_MWAIT;
            end else begin
               exp_in       = exp_ff >> 1;
               mult_done_in = 1'b0;
               if (exp_ff[WIDTH-1:1] != '0) begin
                  mx_in    = base_ff;
                  my_in    = base_ff;
                  dst_in   = DST_BASE;
                  ret_in   = S_POW;
                  start_in = 1'b1;
                  state_in = S_MWAIT;
               end
            end
         end
         S_TEST: begin
            priority if (acc_ff == WIDTH'(1) || acc_ff == nm1_ff) begin
               comp_in  = 1'b0;
               state_in = S_DONE;
            end else if (s_ff <= CNT_W'(1)) begin
               comp_in  = 1'b1;
               state_in = S_DONE;
            end else begin
               left_in  = s_ff - 1'b1;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            if (left_ff == '0) begin
               comp_in  = 1'b1;
               state_in = S_DONE;
            end else begin
               left_in  = left_ff - 1'b1;
               mx_in    = acc_ff;
               my_in    = acc_ff;
               dst_in   = DST_ACC;
               ret_in   = S_SQCHK;
               start_in = 1'b1;
               state_in = S_MWAIT;
            end
         end
         S_SQCHK: begin
            if (acc_ff == nm1_ff) begin
               comp_in  = 1'b0;
               state_in = S_DONE;
            end else begin
               state_in = S_SQ;
            end
         end
         S_DONE: begin
            if (rsp_bus.ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         start_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= start_in;
      end
      ret_ff       <= ret_in;
      dst_ff       <= dst_in;
      mult_done_ff <= mult_done_in;
      comp_ff      <= comp_in;
      n_ff         <= n_in;
      nm1_ff       <= nm1_in;
      exp_ff       <= exp_in;
      acc_ff       <= acc_in;
      base_ff      <= base_in;
      wit_ff       <= wit_in;
      mx_ff        <= mx_in;
      my_ff        <= my_in;
      s_ff         <= s_in;
      left_ff      <= left_in;
   end

   assign req_bus.ready     = (state_ff == S_IDLE);
   assign rsp_bus.valid     = (state_ff == S_DONE);
   assign rsp_bus.composite = comp_ff;
endmodule

/* design/mrw_checker.sv */
// Port-level checks for the Miller-Rabin witness test core, bound to the top level.
// Sees only the handshake ports; no package dependency.
module mrw_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_composite
);
   // A request beat is followed by a busy period.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("ready right after request beat");

   // Only one item is in flight: no new request while a response waits.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("ready while response pending");

   // Once the response beat is taken the core is ready for the next request.
   a_ready_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> req_ready) else $error("not ready after response beat");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_composite))
      else $error("stalled response changed");
endmodule

bind miller_rabin_witness_test_core mrw_checker u_mrw_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_composite(rsp_bus.composite)
);
